// ----- hdl/fbo_pkg.sv -----
// Shared constants, register codes and the saturation helper function of the position feedback observer.
package fbo_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int DATA_W  = 32;
  localparam int DRIVE_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int SAT_IN_W = 68;

  localparam int DOT_W  = 60;
  localparam int DVD_W  = 44;
  localparam int REM_W  = 7;
  localparam int DIV_BITS_PER_CYCLE = 4;
  localparam int DIV_CYCLES = DVD_W / DIV_BITS_PER_CYCLE;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);
  localparam int QUOT_W = 36;

  localparam longint RAD_PER_COUNT_Q36 = 64'sd218510732;
  localparam longint TENTH2_Q32        = 64'sd858993459;
  localparam longint POS_EPS_Q32       = 64'sd128849019;
  localparam int     DRIVE_FRAC        = 14;
  localparam int     CMD_EPS_LSB       = 8;
  localparam int     STEP_DIV          = 100;
  localparam int     STEP_BIAS         = 50;
  localparam longint EULER_LIM         = 64'sd858993459200;
  localparam longint QUOT_OFFSET       = 64'sd8589934592;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZERO_COUNT   = 3'd0,
    REG_REF_POSITION = 3'd1,
    REG_GAIN_POS     = 3'd2,
    REG_GAIN_VEL     = 3'd3,
    REG_OBS_GAIN_POS = 3'd4,
    REG_OBS_GAIN_VEL = 3'd5,
    REG_DAMPING      = 3'd6,
    REG_INPUT_GAIN   = 3'd7
  } cfg_reg_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    hi = SAT_IN_W'(64'sd2147483647);
    lo = -SAT_IN_W'(64'sd2147483648);
    if (v > hi) begin
      return DATA_W'(hi);
    end else if (v < lo) begin
      return DATA_W'(lo);
    end
    return DATA_W'(v);
  endfunction

endpackage

// ----- hdl/fbo_in_if.sv -----
// Input channel carrying one encoder sample per transaction.
interface fbo_in_if;
  logic valid;
  logic ready;
  logic signed [fbo_pkg::DATA_W-1:0] encoder_count;
  logic signed [fbo_pkg::DATA_W-1:0] measured_speed;

  modport source(output valid, encoder_count, measured_speed, input ready);
  modport sink(input valid, encoder_count, measured_speed, output ready);
endinterface

// ----- hdl/fbo_out_if.sv -----
// Output channel carrying one drive command and observer result per transaction.
interface fbo_out_if;
  logic valid;
  logic ready;
  logic signed [fbo_pkg::DRIVE_W-1:0] drive;
  logic drive_update;
  logic signed [fbo_pkg::DATA_W-1:0] measured_angle;
  logic signed [fbo_pkg::DATA_W-1:0] est_angle;
  logic signed [fbo_pkg::DATA_W-1:0] est_speed;

  modport source(output valid, drive, drive_update, measured_angle, est_angle, est_speed,
                 input ready);
  modport sink(input valid, drive, drive_update, measured_angle, est_angle, est_speed,
               output ready);
endinterface

// ----- hdl/fbo_mul.sv -----
// Shared signed multiplier with a registered product.
module fbo_mul (
  input  logic clk,
  input  logic signed [fbo_pkg::MUL_W-1:0] a,
  input  logic signed [fbo_pkg::MUL_W-1:0] b,
  output logic signed [fbo_pkg::PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= fbo_pkg::PROD_W'(a) * fbo_pkg::PROD_W'(b);
  end

endmodule

// ----- hdl/fbo_div.sv -----
// Euler step divider: floor((2*dot + 50) / 100), four quotient bits per cycle, clamped range.
module fbo_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [fbo_pkg::DOT_W-1:0] dot,
  output logic busy,
  output logic signed [fbo_pkg::QUOT_W-1:0] quot
);

  localparam int N_W = fbo_pkg::DOT_W + 2;
  localparam logic signed [N_W-1:0] LIM  = N_W'(fbo_pkg::EULER_LIM);
  localparam logic signed [N_W-1:0] BIAS = N_W'(fbo_pkg::STEP_BIAS);
  localparam logic [fbo_pkg::REM_W:0] DIVISOR = (fbo_pkg::REM_W + 1)'(fbo_pkg::STEP_DIV);
  localparam logic signed [fbo_pkg::QUOT_W-1:0] QOFF = fbo_pkg::QUOT_W'(fbo_pkg::QUOT_OFFSET);

  logic [fbo_pkg::DVD_W-1:0] dvd;
  logic [fbo_pkg::DVD_W-1:0] dvd_next;
  logic [fbo_pkg::REM_W-1:0] rem;
  logic [fbo_pkg::REM_W-1:0] rem_next;
  logic [fbo_pkg::DIV_CNT_W-1:0] cnt;
  logic signed [N_W-1:0] num;
  logic signed [N_W-1:0] num_cl;
  logic signed [N_W-1:0] num_pos;

  always_comb begin
    num = (N_W'(dot) <<< 1) + BIAS;
    if (num > LIM) begin
      num_cl = LIM;
    end else if (num < -LIM) begin
      num_cl = -LIM;
    end else begin
      num_cl = num;
    end
    num_pos = num_cl + LIM;
  end

  always_comb begin
    logic [fbo_pkg::REM_W:0] t;
    dvd_next = dvd;
    rem_next = rem;
    for (int i = 0; i < fbo_pkg::DIV_BITS_PER_CYCLE; i++) begin
      t = {rem_next, dvd_next[fbo_pkg::DVD_W-1]};
      if (t >= DIVISOR) begin
        dvd_next = {dvd_next[fbo_pkg::DVD_W-2:0], 1'b1};
        rem_next = fbo_pkg::REM_W'(t - DIVISOR);
      end else begin
        dvd_next = {dvd_next[fbo_pkg::DVD_W-2:0], 1'b0};
        rem_next = fbo_pkg::REM_W'(t);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= fbo_pkg::DIV_CNT_W'(fbo_pkg::DIV_CYCLES);
      dvd <= fbo_pkg::DVD_W'(num_pos);
      rem <= '0;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      dvd <= dvd_next;
      rem <= rem_next;
    end
  end

  assign busy = (cnt != '0);
  assign quot = $signed({1'b0, dvd[fbo_pkg::QUOT_W-2:0]}) - QOFF;

endmodule

// ----- hdl/position_state_feedback_observer.sv -----
// Top level: state feedback drive with deadband and command hold, plus observer update.
//
//   Channel   Dir  Handshake        Payload
//   sample    in   valid/ready      encoder_count, measured_speed
//   result    out  valid/ready      drive, drive_update, measured_angle, est_angle, est_speed
//   cfg       in   cfg_we           cfg_index, cfg_data
//
// Each transaction makes seven passes through the shared 33x33 multiplier and two passes
// through the divide-by-100 unit, which yields four quotient bits per cycle while busy.
// Reset is synchronous and restores the register defaults and clears the observer state.
// A finished result waits in the output register; the next sample may be accepted meanwhile,
// and its processing holds in its last step until the output register is free.
module position_state_feedback_observer #(
  parameter int FRAC_BITS = fbo_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  fbo_in_if.sink   sample,
  fbo_out_if.source result,
  input  logic cfg_we,
  input  logic [fbo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbo_pkg::DATA_W-1:0] cfg_data
);

  localparam int DW = fbo_pkg::DATA_W;
  localparam int MW = fbo_pkg::MUL_W;
  localparam int PW = fbo_pkg::PROD_W;
  localparam int AW = fbo_pkg::ACC_W;
  localparam int SW = fbo_pkg::SAT_IN_W;
  localparam int ANG_SH = 36 - FRAC_BITS;
  localparam int DRV_SH = 2 * FRAC_BITS - fbo_pkg::DRIVE_FRAC;

  localparam longint DB_POS_Q =
      (fbo_pkg::POS_EPS_Q32 + (longint'(1) << (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
  localparam longint DB_SPD_Q =
      (fbo_pkg::TENTH2_Q32 + (longint'(1) << (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);

  localparam logic signed [MW-1:0] DB_POS = MW'(DB_POS_Q);
  localparam logic signed [MW-1:0] DB_SPD = MW'(DB_SPD_Q);
  localparam logic signed [MW-1:0] K_ANG  = MW'(fbo_pkg::RAD_PER_COUNT_Q36);

  localparam logic signed [AW-1:0] HALF_ANG = AW'(longint'(1) << (ANG_SH - 1));
  localparam logic signed [AW-1:0] HALF_F   = AW'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [AW-1:0] HALF_14  = AW'(longint'(1) << (fbo_pkg::DRIVE_FRAC - 1));
  localparam logic signed [AW-1:0] HALF_DRV = AW'(longint'(1) << (DRV_SH - 1));
  localparam logic signed [AW-1:0] ONE_WIDE = AW'(longint'(1) << (2 * FRAC_BITS));

  localparam logic signed [fbo_pkg::DRIVE_W:0] CMD_EPS =
      (fbo_pkg::DRIVE_W + 1)'(fbo_pkg::CMD_EPS_LSB);

  localparam logic signed [DW-1:0] RST_REF  = DW'(longint'(1) << FRAC_BITS);
  localparam logic signed [DW-1:0] RST_GP   = DW'(longint'(2) << FRAC_BITS);
  localparam logic signed [DW-1:0] RST_GV   = DW'(DB_SPD_Q);
  localparam logic signed [DW-1:0] RST_L1   = DW'(longint'(20) << FRAC_BITS);
  localparam logic signed [DW-1:0] RST_L2   = DW'(longint'(120) << FRAC_BITS);
  localparam logic signed [DW-1:0] RST_DAMP = DW'(longint'(4) << FRAC_BITS);
  localparam logic signed [DW-1:0] RST_BGN  = DW'(longint'(25) << FRAC_BITS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_ANG,
    S_ANGLE,
    S_MUL_GP,
    S_MUL_GV,
    S_MUL_L1,
    S_DRIVE,
    S_MUL_B,
    S_MUL_L2,
    S_SUM,
    S_EST_ANG,
    S_EST_SPD
  } state_t;

  state_t state;

  logic signed [DW-1:0] zero_count;
  logic signed [DW-1:0] ref_position;
  logic signed [DW-1:0] gain_position;
  logic signed [DW-1:0] gain_velocity;
  logic signed [DW-1:0] obs_gain_position;
  logic signed [DW-1:0] obs_gain_velocity;
  logic signed [DW-1:0] plant_damping;
  logic signed [DW-1:0] plant_input_gain;

  logic signed [fbo_pkg::DRIVE_W-1:0] held_drive;
  logic held_valid;
  logic signed [DW-1:0] angle_estimate;
  logic signed [DW-1:0] speed_estimate;

  logic signed [DW-1:0] count;
  logic signed [DW-1:0] meas_speed;
  logic signed [DW-1:0] angle;
  logic deadband;
  logic update;
  logic signed [AW-1:0] acc;
  logic signed [fbo_pkg::DOT_W-1:0] dot1;

  logic out_valid;
  logic signed [fbo_pkg::DRIVE_W-1:0] out_drive;
  logic out_update;
  logic signed [DW-1:0] out_angle;
  logic signed [DW-1:0] out_est_angle;
  logic signed [DW-1:0] out_est_speed;

  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic signed [PW-1:0] prod;

  logic div_start;
  logic div_busy;
  logic signed [fbo_pkg::DOT_W-1:0] div_dot;
  logic signed [fbo_pkg::QUOT_W-1:0] quot;

  logic signed [MW-1:0] nrel;
  logic signed [MW-1:0] pos_err;
  logic signed [MW-1:0] speed;
  logic signed [DW-1:0] innov;
  logic signed [AW-1:0] prod_x;
  logic signed [AW-1:0] ang_rnd;
  logic signed [AW-1:0] rnd_f;
  logic signed [AW-1:0] rnd_14;
  logic signed [AW-1:0] u_cl;
  logic signed [AW-1:0] drv_rnd;
  logic signed [fbo_pkg::DRIVE_W-1:0] drive_new;
  logic signed [fbo_pkg::DRIVE_W:0] drive_diff;
  logic update_next;
  logic signed [DW-1:0] est_next;
  logic out_free;

  fbo_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .prod(prod)
  );

  fbo_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .dot  (div_dot),
    .busy (div_busy),
    .quot (quot)
  );

  always_comb begin
    nrel    = MW'(zero_count) - MW'(count);
    pos_err = MW'(angle) - MW'(ref_position);
    speed   = -MW'(meas_speed);
    innov   = fbo_pkg::sat32(SW'(MW'(angle) - MW'(angle_estimate)));
    prod_x  = AW'(prod);
    ang_rnd = (prod_x + HALF_ANG) >>> ANG_SH;
    rnd_f   = (prod_x + HALF_F) >>> FRAC_BITS;
    rnd_14  = (prod_x + HALF_14) >>> fbo_pkg::DRIVE_FRAC;
    if (acc > ONE_WIDE) begin
      u_cl = ONE_WIDE;
    end else if (acc < -ONE_WIDE) begin
      u_cl = -ONE_WIDE;
    end else begin
      u_cl = acc;
    end
    drv_rnd = (u_cl + HALF_DRV) >>> DRV_SH;
    drive_new = deadband ? '0 : fbo_pkg::DRIVE_W'(drv_rnd);
    drive_diff = (fbo_pkg::DRIVE_W + 1)'(drive_new) - (fbo_pkg::DRIVE_W + 1)'(held_drive);
    update_next = !held_valid || (drive_diff > CMD_EPS) || (drive_diff < -CMD_EPS);
    est_next = (state == S_EST_ANG)
             ? fbo_pkg::sat32(SW'(angle_estimate) + SW'(quot))
             : fbo_pkg::sat32(SW'(speed_estimate) + SW'(quot));
    out_free = !out_valid || result.ready;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MUL_ANG: begin
        mul_a = nrel;
        mul_b = K_ANG;
      end
      S_MUL_GP: begin
        mul_a = MW'(gain_position);
        mul_b = MW'(fbo_pkg::sat32(SW'(pos_err)));
      end
      S_MUL_GV: begin
        mul_a = MW'(gain_velocity);
        mul_b = MW'(fbo_pkg::sat32(SW'(speed)));
      end
      S_MUL_L1: begin
        mul_a = MW'(obs_gain_position);
        mul_b = MW'(innov);
      end
      S_DRIVE: begin
        mul_a = -MW'(plant_damping);
        mul_b = MW'(speed_estimate);
      end
      S_MUL_B: begin
        mul_a = MW'(plant_input_gain);
        mul_b = MW'(held_drive);
      end
      S_MUL_L2: begin
        mul_a = MW'(obs_gain_velocity);
        mul_b = MW'(innov);
      end
      S_IDLE, S_ANGLE, S_SUM, S_EST_ANG, S_EST_SPD: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_start = (state == S_MUL_B) || ((state == S_EST_ANG) && !div_busy);
  assign div_dot   = (state == S_EST_ANG) ? fbo_pkg::DOT_W'(acc) : dot1;

  assign sample.ready        = (state == S_IDLE);
  assign result.valid        = out_valid;
  assign result.drive        = out_drive;
  assign result.drive_update = out_update;
  assign result.measured_angle = out_angle;
  assign result.est_angle    = out_est_angle;
  assign result.est_speed    = out_est_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      zero_count        <= '0;
      ref_position      <= RST_REF;
      gain_position     <= RST_GP;
      gain_velocity     <= RST_GV;
      obs_gain_position <= RST_L1;
      obs_gain_velocity <= RST_L2;
      plant_damping     <= RST_DAMP;
      plant_input_gain  <= RST_BGN;
      held_drive        <= '0;
      held_valid        <= 1'b0;
      angle_estimate    <= '0;
      speed_estimate    <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (fbo_pkg::cfg_reg_t'(cfg_index))
          fbo_pkg::REG_ZERO_COUNT:   zero_count        <= cfg_data;
          fbo_pkg::REG_REF_POSITION: ref_position      <= cfg_data;
          fbo_pkg::REG_GAIN_POS:     gain_position     <= cfg_data;
          fbo_pkg::REG_GAIN_VEL:     gain_velocity     <= cfg_data;
          fbo_pkg::REG_OBS_GAIN_POS: obs_gain_position <= cfg_data;
          fbo_pkg::REG_OBS_GAIN_VEL: obs_gain_velocity <= cfg_data;
          fbo_pkg::REG_DAMPING:      plant_damping     <= cfg_data;
          fbo_pkg::REG_INPUT_GAIN:   plant_input_gain  <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            count      <= sample.encoder_count;
            meas_speed <= sample.measured_speed;
            state      <= S_MUL_ANG;
          end
        end
        S_MUL_ANG: begin
          state <= S_ANGLE;
        end
        S_ANGLE: begin
          angle <= fbo_pkg::sat32(SW'(ang_rnd));
          state <= S_MUL_GP;
        end
        S_MUL_GP: begin
          deadband <= (pos_err < DB_POS) && (pos_err > -DB_POS) &&
                      (speed < DB_SPD) && (speed > -DB_SPD);
          state <= S_MUL_GV;
        end
        S_MUL_GV: begin
          acc   <= -prod_x;
          state <= S_MUL_L1;
        end
        S_MUL_L1: begin
          acc   <= acc - prod_x;
          state <= S_DRIVE;
        end
        S_DRIVE: begin
          update <= update_next;
          if (update_next) begin
            held_drive <= drive_new;
            held_valid <= 1'b1;
          end
          dot1  <= fbo_pkg::DOT_W'(rnd_f + AW'(speed_estimate));
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          acc   <= rnd_f;
          state <= S_MUL_L2;
        end
        S_MUL_L2: begin
          acc   <= acc + rnd_14;
          state <= S_SUM;
        end
        S_SUM: begin
          acc   <= acc + rnd_f;
          state <= S_EST_ANG;
        end
        S_EST_ANG: begin
          if (!div_busy) begin
            angle_estimate <= est_next;
            state          <= S_EST_SPD;
          end
        end
        S_EST_SPD: begin
          if (!div_busy && out_free) begin
            speed_estimate <= est_next;
            out_valid      <= 1'b1;
            out_drive      <= held_drive;
            out_update     <= update;
            out_angle      <= angle;
            out_est_angle  <= angle_estimate;
            out_est_speed  <= est_next;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
